// ===== hdl/bdl_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended list: shared package
// Types and constants used by the ring memory, the controller and the top
// level of the bounded double-ended list unit.
// ----------------------------------------------------------------------------
package bdl_pkg;

  // Ring capacity and the widths that follow from it.
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned PTR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W    = PTR_W + 2;
  localparam int unsigned DATA_W   = 32;

  // Operation codes of an incoming word.
  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  // Which end of the list takes its value from the memory read data.
  typedef enum logic [1:0] {
    RSEL_NONE  = 2'd0,
    RSEL_FRONT = 2'd1,
    RSEL_BACK  = 2'd2
  } rsel_e;

  // Incoming command word.
  typedef struct packed {
    op_e                       kind;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  // Outgoing result word.
  typedef struct packed {
    logic [6:0]                entry_count;
    logic                      is_empty;
    logic                      is_full;
    logic                      refused;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
  } result_t;

  // Access request from the controller to the ring memory.
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ===== hdl/bounded_double_ended_list_unit.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended list unit
// A ring of 64 signed 32-bit entries with inserts and deletes at both ends.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+------------------------------
//   command  | start, busy, cmd_i          | taken when start && !busy
//   result   | res_strobe_o, res_o         | one cycle strobe, no stall
//
// A command word is taken in any cycle; its result appears on the cycle
// after it is taken, so one word per cycle is sustained. The single ring
// memory port pair (one write, one registered read) sets that latency: a
// delete fetches the new end value, read in the cycle its result appears.
// busy stays low. Reset empties the list; the memory itself is not cleared.
// The receiver cannot stall, so a result is never held.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bdl_pkg::cmd_t     cmd_i,
  output logic              res_strobe_o,
  output bdl_pkg::result_t  res_o
);

  logic                        accept;
  bdl_pkg::mem_req_t           mem_req;
  logic [bdl_pkg::DATA_W-1:0]  mem_rdata;

  // Every word is taken in the cycle it is offered.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Controller.
  bdl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .rdata_i  (mem_rdata),
    .req_o    (mem_req),
    .strobe_o (res_strobe_o),
    .result_o (res_o)
  );

  // Ring memory.
  bdl_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== hdl/bdl_ram.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended list: ring memory
// Single write port, single read port with registered read data. The read
// data register holds its value until the next read.
// ----------------------------------------------------------------------------
module bdl_ram (
  input  logic                        clk_i,
  input  bdl_pkg::mem_req_t           req_i,
  output logic [bdl_pkg::DATA_W-1:0]  rdata_o
);

  logic [bdl_pkg::DATA_W-1:0] mem [bdl_pkg::CAPACITY];
  logic [bdl_pkg::DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended list: controller
// Keeps the head position and the count, issues at most one memory access per
// word and caches the front and back values. A delete fetches the new end
// value from memory; the result is formed in the following cycle from the
// cache or the read data.
// ----------------------------------------------------------------------------
module bdl_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  bdl_pkg::cmd_t               cmd_i,
  input  logic [bdl_pkg::DATA_W-1:0]  rdata_i,
  output bdl_pkg::mem_req_t           req_o,
  output logic                        strobe_o,
  output bdl_pkg::result_t            result_o
);

  localparam int unsigned PTR_W  = bdl_pkg::PTR_W;
  localparam int unsigned CNT_W  = bdl_pkg::CNT_W;
  localparam int unsigned SUM_W  = bdl_pkg::SUM_W;
  localparam int unsigned DATA_W = bdl_pkg::DATA_W;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PTR_W-1:0]   head_q, head_d;
  bdl_pkg::rsel_e     rsel_q, rsel_d;
  logic               strobe_q;
  logic               refused_q, refused_d;
  logic [DATA_W-1:0]  front_q, front_d;
  logic [DATA_W-1:0]  back_q, back_d;

  logic               is_full, is_empty;
  logic [DATA_W-1:0]  cur_front, cur_back;
  logic [SUM_W-1:0]   tail_sum, last_sum;
  logic [PTR_W-1:0]   tail_idx, new_last_idx, head_inc, head_dec;
  logic               out_empty;

  // Current end values: a pending memory fetch overrides the cache.
  assign cur_front = (rsel_q == bdl_pkg::RSEL_FRONT) ? rdata_i : front_q;
  assign cur_back  = (rsel_q == bdl_pkg::RSEL_BACK)  ? rdata_i : back_q;

  assign is_full  = (cnt_q == CNT_W'(bdl_pkg::CAPACITY));
  assign is_empty = (cnt_q == '0);

  // Ring index arithmetic; each sum is below twice the capacity if cnt_q >= 2.
  assign tail_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
  assign last_sum = SUM_W'(head_q) + SUM_W'(cnt_q) - SUM_W'(2);
  assign tail_idx = (tail_sum >= SUM_W'(bdl_pkg::CAPACITY))
                    ? PTR_W'(tail_sum - SUM_W'(bdl_pkg::CAPACITY)) : PTR_W'(tail_sum);
  assign new_last_idx = (last_sum >= SUM_W'(bdl_pkg::CAPACITY))
                    ? PTR_W'(last_sum - SUM_W'(bdl_pkg::CAPACITY)) : PTR_W'(last_sum);
  assign head_inc = (head_q == PTR_W'(bdl_pkg::CAPACITY - 1)) ? '0 : head_q + PTR_W'(1);
  assign head_dec = (head_q == '0) ? PTR_W'(bdl_pkg::CAPACITY - 1) : head_q - PTR_W'(1);

  // Next state and memory request for an accepted word.
  always_comb begin
    cnt_d     = cnt_q;
    head_d    = head_q;
    rsel_d    = bdl_pkg::RSEL_NONE;
    refused_d = 1'b0;
    front_d   = cur_front;
    back_d    = cur_back;
    req_o     = '0;
    unique case (cmd_i.kind)
      bdl_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          refused_d = 1'b1;
        end else begin
          req_o.we    = accept_i;
          req_o.waddr = tail_idx;
          req_o.wdata = cmd_i.value;
          cnt_d       = cnt_q + CNT_W'(1);
          back_d      = cmd_i.value;
          if (is_empty) begin
            front_d = cmd_i.value;
          end
        end
      end
      bdl_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          refused_d = 1'b1;
        end else begin
          req_o.we    = accept_i;
          req_o.waddr = head_dec;
          req_o.wdata = cmd_i.value;
          head_d      = head_dec;
          cnt_d       = cnt_q + CNT_W'(1);
          front_d     = cmd_i.value;
          if (is_empty) begin
            back_d = cmd_i.value;
          end
        end
      end
      bdl_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          refused_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q != CNT_W'(1)) begin
            req_o.re    = accept_i;
            req_o.raddr = new_last_idx;
            rsel_d      = bdl_pkg::RSEL_BACK;
          end
        end
      end
      bdl_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          refused_d = 1'b1;
        end else begin
          cnt_d  = cnt_q - CNT_W'(1);
          head_d = head_inc;
          if (cnt_q != CNT_W'(1)) begin
            req_o.re    = accept_i;
            req_o.raddr = head_inc;
            rsel_d      = bdl_pkg::RSEL_FRONT;
          end
        end
      end
      default: begin
        refused_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      head_q   <= '0;
      rsel_q   <= bdl_pkg::RSEL_NONE;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= accept_i;
      if (accept_i) begin
        cnt_q  <= cnt_d;
        head_q <= head_d;
        rsel_q <= rsel_d;
      end
    end
  end

  // Cached end values and refusal flag.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      refused_q <= refused_d;
      front_q   <= front_d;
      back_q    <= back_d;
    end
  end

  // Result word: ends read as zero when the list is empty.
  assign out_empty = (cnt_q == '0);

  always_comb begin
    result_o             = '0;
    result_o.entry_count = 7'(cnt_q);
    result_o.is_empty    = out_empty;
    result_o.is_full     = (cnt_q == CNT_W'(bdl_pkg::CAPACITY));
    result_o.refused     = refused_q;
    if (!out_empty) begin
      result_o.front_value = cur_front;
      result_o.back_value  = cur_back;
    end
  end

  assign strobe_o = strobe_q;

endmodule

// ===== sim/bounded_double_ended_list_unit_test.sv =====
// ----------------------------------------------------------------------------
// Bounded double-ended list unit: self-checking testbench
// Drives insert and delete words at both ends of the list, predicts every
// result word from a behavioural copy of the ring, and compares each result
// field by field. A short directed part covers the value extremes, every
// operation and refusals on an empty list. Random fill and drain bursts then
// take the list to full and back to empty many times, with the sender idling
// at several rates.
// ----------------------------------------------------------------------------
module bounded_double_ended_list_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW  = bdl_pkg::DATA_W;
  localparam int unsigned PW  = bdl_pkg::PTR_W;
  localparam int unsigned CAP = bdl_pkg::CAPACITY;

  // Clock, reset and the block's inputs, all known from time zero.
  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start  = 1'b0;
  bdl_pkg::cmd_t    cmd_i  = '0;
  logic             busy;
  logic             res_strobe_o;
  bdl_pkg::result_t res_o;

  bounded_double_ended_list_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // Words waiting to be sent and results waiting to arrive.
  bdl_pkg::cmd_t    pending_words[$];
  bdl_pkg::result_t awaited_results[$];
  int               idle_pct = 0;

  // Behavioural copy of the list.
  logic [DW-1:0]    ring_copy[CAP];
  int unsigned      head_copy  = 0;
  int unsigned      count_copy = 0;

  int               errors       = 0;
  int               words_sent   = 0;
  int               results_seen = 0;
  int               refusals     = 0;
  int               full_seen    = 0;
  int               empty_seen   = 0;
  bdl_pkg::result_t got_res;
  bdl_pkg::result_t want_res;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one word to the copy of the list and returns the result it causes.
  function automatic bdl_pkg::result_t apply_to_list(bdl_pkg::cmd_t word);
    bdl_pkg::result_t res;
    res = '0;
    case (word.kind)
      bdl_pkg::OP_PUSH_BACK: begin
        if (count_copy >= CAP) begin
          res.refused = 1'b1;
        end else begin
          ring_copy[PW'((head_copy + count_copy) % CAP)] = word.value;
          count_copy++;
        end
      end
      bdl_pkg::OP_PUSH_FRONT: begin
        if (count_copy >= CAP) begin
          res.refused = 1'b1;
        end else begin
          head_copy = (head_copy + CAP - 1) % CAP;
          ring_copy[PW'(head_copy)] = word.value;
          count_copy++;
        end
      end
      bdl_pkg::OP_POP_BACK: begin
        if (count_copy == 0) res.refused = 1'b1;
        else count_copy--;
      end
      default: begin
        if (count_copy == 0) begin
          res.refused = 1'b1;
        end else begin
          head_copy = (head_copy + 1) % CAP;
          count_copy--;
        end
      end
    endcase
    // Both ends read as zero on an empty list.
    if (count_copy != 0) begin
      res.front_value = ring_copy[PW'(head_copy)];
      res.back_value  = ring_copy[PW'((head_copy + count_copy - 1) % CAP)];
    end
    res.entry_count = count_copy[6:0];
    res.is_empty    = (count_copy == 0);
    res.is_full     = (count_copy >= CAP);
    return res;
  endfunction

  // Picks an insert value, with the extremes turning up often.
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // A random word; a filling burst mostly inserts, a draining burst mostly deletes.
  function automatic bdl_pkg::cmd_t random_word(bit filling);
    bdl_pkg::cmd_t word;
    bit            insert;
    insert     = filling ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
    word.value = pick_value();
    if (insert) begin
      word.kind = $urandom_range(1) ? bdl_pkg::OP_PUSH_FRONT : bdl_pkg::OP_PUSH_BACK;
    end else begin
      word.kind = $urandom_range(1) ? bdl_pkg::OP_POP_FRONT : bdl_pkg::OP_POP_BACK;
    end
    return word;
  endfunction

  function automatic bdl_pkg::cmd_t make_word(bdl_pkg::op_e kind, logic [DW-1:0] value);
    bdl_pkg::cmd_t word;
    word.kind  = kind;
    word.value = value;
    return word;
  endfunction

  task automatic check_field(string field, logic [DW-1:0] want, logic [DW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
    end
  endtask

  // Driver: holds a word until it is taken, then sends the next one or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(apply_to_list(cmd_i));
        words_sent++;
      end
      if (start && busy) begin
        // The current word has not been taken yet, so it stays on the port.
      end else if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cmd_i <= pending_words.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      got_res = res_o;
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %h", $realtime, got_res);
      end else begin
        want_res = awaited_results.pop_front();
        check_field("entry_count", DW'(want_res.entry_count), DW'(got_res.entry_count));
        check_field("is_empty", DW'(want_res.is_empty), DW'(got_res.is_empty));
        check_field("is_full", DW'(want_res.is_full), DW'(got_res.is_full));
        check_field("refused", DW'(want_res.refused), DW'(got_res.refused));
        check_field("front_value", want_res.front_value, got_res.front_value);
        check_field("back_value", want_res.back_value, got_res.back_value);
        if (want_res.refused)  refusals++;
        if (want_res.is_full)  full_seen++;
        if (want_res.is_empty) empty_seen++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int idle_plan[8];
    idle_plan = '{0, 61, 23, 0, 61, 23, 0, 61};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: refusals on an empty list, value extremes, all operations.
    pending_words.push_back(make_word(bdl_pkg::OP_POP_BACK,   32'h1234_5678));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'h8765_4321));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_BACK,  32'h7fff_ffff));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_FRONT, 32'h8000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_BACK,  32'h0000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_FRONT, 32'hffff_ffff));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'h0000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_BACK,   32'hffff_ffff));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_BACK,   32'h0000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'hffff_ffff));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'h0000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_FRONT, 32'h5555_5555));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_BACK,  32'haaaa_aaaa));
    pending_words.push_back(make_word(bdl_pkg::OP_PUSH_FRONT, 32'h0000_0001));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_BACK,   32'h5555_5555));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'haaaa_aaaa));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_FRONT,  32'h0000_0000));
    pending_words.push_back(make_word(bdl_pkg::OP_POP_BACK,   32'h0000_0000));
    while (pending_words.size() != 0) @(negedge clk_i);

    // Random part: alternating fill and drain bursts reach full and empty often.
    for (int burst = 0; burst < 8; burst++) begin
      idle_pct = idle_plan[burst];
      for (int n = 0; n < 100; n++) pending_words.push_back(random_word(burst % 2 == 0));
      while (pending_words.size() != 0) @(negedge clk_i);
    end

    // Let the last word go and every awaited result arrive, then a short tail.
    while (start || awaited_results.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $realtime, awaited_results.size());
    end
    $display("Sent %0d words and checked %0d results: %0d refused, %0d on a full list,",
             words_sent, results_seen, refusals, full_seen);
    $display("%0d on an empty list, with sender idling at 0, 23 and 61 percent.", empty_seen);
    if (errors == 0) begin
      $display("bounded_double_ended_list_unit verification clean");
    end else begin
      $display("bounded_double_ended_list_unit verification failed");
    end
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #1ms;
    $display("Run timed out");
    $display("bounded_double_ended_list_unit verification failed");
    $finish;
  end

endmodule
